@@ src/u8d_pkg.sv @@
`default_nettype none

package u8d_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned CpW       = 21;
    localparam int unsigned MaxRes    = 4;
    localparam int unsigned CntW      = 3;
    localparam int unsigned OutDataW  = 24;

    localparam logic [CpW-1:0] EscBase   = 21'h00DC80;
    localparam logic [CpW-1:0] MinTwo    = 21'h000080;
    localparam logic [CpW-1:0] MinThree  = 21'h000800;
    localparam logic [CpW-1:0] MinFour   = 21'h010000;
    localparam logic [9:0]     SurrHigh  = 10'h01B;

    typedef struct packed {
        logic [CpW-1:0] cp;
        logic           esc;
    } result_t;

    typedef struct packed {
        logic [ByteW-1:0]      lead;
        logic [1:0][ByteW-1:0] follow;
        logic [1:0]            follow_count;
        logic [1:0]            bytes_wanted;
        logic [CpW-1:0]        accum;
    } dec_state_t;

    typedef struct packed {
        result_t [MaxRes-1:0] res;
        logic [CntW-1:0]      cnt;
    } burst_t;

    function automatic result_t esc_of(input logic [ByteW-1:0] b);
        result_t r;
        r.cp  = EscBase | {{(CpW-ByteW){1'b0}}, b};
        r.esc = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/utf8_decoder_with_error_escape.sv @@
// UTF-8 decoder with error escape.
// Input stream: one byte of encoded text per item on s_axis_tdata, with
// s_axis_tlast on the last byte of a string (flushes any open sequence).
// Output stream: one code point per item on m_axis_tdata; m_axis_tuser
// flags an escaped raw byte (0xDC80 | byte); m_axis_tlast marks the last
// result caused by one input byte.
// Each accepted byte yields 0 to 4 results. Results appear in the cycle after
// the byte is accepted and leave one per cycle from the result register
// while the receiver is ready. Valid text runs at one byte per cycle when the
// receiver is ready. An input byte that causes more than one result holds
// s_axis_tready low while the result register drains; a byte causing no result leaves it high.
// Reset clears the open sequence and empties the result register.
// When the receiver stalls, the pending result holds and input is taken
// only once the last pending result is leaving.
`default_nettype none

module utf8_decoder_with_error_escape
    import u8d_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [ByteW-1:0]    s_axis_tdata,   // [7:0] byte_in
    input  wire logic                s_axis_tlast,   // end_of_string
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OutDataW-1:0]      m_axis_tdata,   // [20:0] code_point, rest zero
    output logic [0:0]               m_axis_tuser,   // [0] is_escape
    output logic                     m_axis_tlast    // last_of_run
);

    dec_state_t           st_reg;
    dec_state_t           st_next;
    burst_t               burst;
    result_t [MaxRes-1:0] res_reg;
    logic [CntW-1:0]      rem_reg;
    logic [CntW-1:0]      rem_next;
    logic [1:0]           idx_reg;
    logic [1:0]           idx_next;
    logic                 in_acc;
    logic                 out_acc;
    result_t              cur;

    u8d_decode u_decode (
        .st      (st_reg),
        .byte_in (s_axis_tdata),
        .eos     (s_axis_tlast),
        .st_next (st_next),
        .burst   (burst)
    );

    assign m_axis_tvalid = (rem_reg != '0);
    assign s_axis_tready = (rem_reg == '0) || ((rem_reg == CntW'(1)) && m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    assign cur           = res_reg[idx_reg];
    assign m_axis_tdata  = {{(OutDataW-CpW){1'b0}}, cur.cp};
    assign m_axis_tuser  = cur.esc;
    assign m_axis_tlast  = (rem_reg == CntW'(1));

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (in_acc)
        begin
            rem_next = burst.cnt;
            idx_next = 2'd0;
        end
        else if (out_acc)
        begin
            rem_next = rem_reg - CntW'(1);
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.lead         <= '0;
            st_reg.follow       <= '0;
            st_reg.follow_count <= '0;
            st_reg.bytes_wanted <= '0;
            st_reg.accum        <= '0;
            rem_reg             <= '0;
            idx_reg             <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                st_reg.lead         <= st_next.lead;
                st_reg.follow       <= st_next.follow;
                st_reg.follow_count <= st_next.follow_count;
                st_reg.bytes_wanted <= st_next.bytes_wanted;
                st_reg.accum        <= st_next.accum;
            end
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            res_reg <= burst.res;
        end
    end

`ifndef SYNTHESIS
    a_rem_max: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= CntW'(MaxRes))
        else $error("result count out of range");

    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (rem_reg <= CntW'(1)))
        else $error("input taken while results pending");

    a_burst_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (burst.cnt != '0)) |=> m_axis_tvalid)
        else $error("results lost after accept");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.bytes_wanted == 2'd0) |-> (st_reg.follow_count == 2'd0))
        else $error("buffered bytes with no open sequence");

    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, st_reg.follow_count} + {1'b0, st_reg.bytes_wanted}) <= 3'd3)
        else $error("sequence length exceeds four bytes");
`endif

endmodule

`default_nettype wire

@@ src/u8d_decode.sv @@
`default_nettype none

module u8d_decode
    import u8d_pkg::*;
(
    input  wire dec_state_t        st,
    input  wire logic [ByteW-1:0]  byte_in,
    input  wire logic              eos,
    output dec_state_t             st_next,
    output burst_t                 burst
);

    logic           is_cont;
    logic           f_ascii;
    logic           f_lead_ok;
    logic [1:0]     f_want;
    logic [CpW-1:0] f_bits;
    logic [CpW-1:0] ch;
    logic [CpW-1:0] min_val;
    logic           bad_val;
    logic           do_fresh;
    logic [1:0]     pre_n;
    logic           tail_v;
    result_t        tail;
    result_t [2:0]  prefix;

    assign is_cont = (byte_in[7:6] == 2'b10);
    assign f_ascii = ~byte_in[7];
    assign ch      = {st.accum[CpW-7:0], byte_in[5:0]};

    always_comb
    begin
        f_lead_ok = 1'b1;
        f_want    = 2'd0;
        f_bits    = '0;
        if (byte_in[7:5] == 3'b110)
        begin
            f_want = 2'd1;
            f_bits = {16'd0, byte_in[4:0]};
        end
        else if (byte_in[7:4] == 4'b1110)
        begin
            f_want = 2'd2;
            f_bits = {17'd0, byte_in[3:0]};
        end
        else if (byte_in[7:3] == 5'b11110)
        begin
            f_want = 2'd3;
            f_bits = {18'd0, byte_in[2:0]};
        end
        else
        begin
            f_lead_ok = 1'b0;
        end
    end

    always_comb
    begin
        if (st.lead[7:5] == 3'b110)
            min_val = MinTwo;
        else if (st.lead[7:4] == 4'b1110)
            min_val = MinThree;
        else
            min_val = MinFour;
    end

    assign bad_val = (ch < min_val) || (ch[CpW-1:11] == SurrHigh);

    assign prefix[0] = esc_of(st.lead);
    assign prefix[1] = esc_of(st.follow[0]);
    assign prefix[2] = esc_of(st.follow[1]);

    always_comb
    begin
        st_next  = st;
        do_fresh = 1'b0;
        pre_n    = 2'd0;
        tail_v   = 1'b0;
        tail     = esc_of(byte_in);
        if (st.bytes_wanted == 2'd0)
        begin
            do_fresh = 1'b1;
        end
        else if (is_cont)
        begin
            if (st.bytes_wanted == 2'd1)
            begin
                tail_v = 1'b1;
                if (bad_val)
                begin
                    pre_n = 2'd1 + st.follow_count;
                end
                else
                begin
                    tail.cp  = ch;
                    tail.esc = 1'b0;
                end
                st_next.bytes_wanted = 2'd0;
                st_next.follow_count = 2'd0;
                st_next.accum        = '0;
            end
            else if (eos)
            begin
                tail_v               = 1'b1;
                pre_n                = 2'd1 + st.follow_count;
                st_next.bytes_wanted = 2'd0;
                st_next.follow_count = 2'd0;
                st_next.accum        = '0;
            end
            else
            begin
                st_next.follow[st.follow_count[0]] = byte_in;
                st_next.follow_count = st.follow_count + 2'd1;
                st_next.bytes_wanted = st.bytes_wanted - 2'd1;
                st_next.accum        = ch;
            end
        end
        else
        begin
            pre_n                = 2'd1 + st.follow_count;
            do_fresh             = 1'b1;
            st_next.bytes_wanted = 2'd0;
            st_next.follow_count = 2'd0;
            st_next.accum        = '0;
        end

        if (do_fresh)
        begin
            if (f_ascii)
            begin
                tail_v   = 1'b1;
                tail.cp  = {13'd0, byte_in};
                tail.esc = 1'b0;
            end
            else if (!f_lead_ok || eos)
            begin
                tail_v = 1'b1;
            end
            else
            begin
                st_next.lead         = byte_in;
                st_next.bytes_wanted = f_want;
                st_next.follow_count = 2'd0;
                st_next.accum        = f_bits;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MaxRes; i++)
        begin
            if (i < int'(pre_n))
                burst.res[i] = prefix[i];
            else
                burst.res[i] = tail;
        end
        burst.cnt = {1'b0, pre_n} + {2'b00, tail_v};
    end

endmodule

`default_nettype wire

@@ dv/utf8_decoder_with_error_escape_tb.sv @@
`default_nettype none

module utf8_decoder_with_error_escape_tb;
    import u8d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ByteW-1:0] b;
        logic             eos;
    } text_byte_t;

    typedef struct packed {
        logic [CpW-1:0] cp;
        logic           esc;
        logic           last;
    } code_point_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [ByteW-1:0]    s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [0:0]          m_axis_tuser;
    logic                m_axis_tlast;

    text_byte_t  pending_bytes[$];
    code_point_t expected_cps[$];
    text_byte_t  next_byte;
    code_point_t want;
    int          errors = 0;
    int          n_accepted = 0;
    logic        steady;

    // decoder state of the predictor
    logic [ByteW-1:0] lead_held = '0;
    logic [ByteW-1:0] follow_buf[2];
    logic [1:0]       follow_count = '0;
    logic [1:0]       bytes_wanted = '0;
    logic [CpW-1:0]   accum = '0;
    code_point_t      step_res[MaxRes];
    int               step_n;

    utf8_decoder_with_error_escape dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    assign steady = (n_accepted >= 80) && (n_accepted < 150);

    task automatic add_result(input logic [CpW-1:0] cp, input logic esc);
        step_res[step_n].cp   = cp;
        step_res[step_n].esc  = esc;
        step_res[step_n].last = 1'b0;
        step_n++;
    endtask

    task automatic add_escape(input logic [ByteW-1:0] b);
        add_result(EscBase | CpW'(b), 1'b1);
    endtask

    task automatic close_sequence();
        bytes_wanted = '0;
        follow_count = '0;
        accum        = '0;
    endtask

    task automatic flush_held();
        add_escape(lead_held);
        for (int k = 0; k < int'(follow_count) && k < 2; k++)
            add_escape(follow_buf[k]);
        close_sequence();
    endtask

    task automatic fresh_byte(input logic [ByteW-1:0] b, input logic eos);
        logic [1:0]     want_n;
        logic [CpW-1:0] bits;
        if (!b[7])
        begin
            add_result(CpW'(b), 1'b0);
            return;
        end
        if (b[7:5] == 3'b110)
        begin
            want_n = 2'd1;
            bits   = CpW'(b[4:0]);
        end
        else if (b[7:4] == 4'b1110)
        begin
            want_n = 2'd2;
            bits   = CpW'(b[3:0]);
        end
        else if (b[7:3] == 5'b11110)
        begin
            want_n = 2'd3;
            bits   = CpW'(b[2:0]);
        end
        else
        begin
            add_escape(b);
            return;
        end
        if (eos)
        begin
            add_escape(b);
            return;
        end
        lead_held    = b;
        bytes_wanted = want_n;
        follow_count = '0;
        accum        = bits;
    endtask

    task automatic decode_byte(input logic [ByteW-1:0] b, input logic eos);
        logic [CpW-1:0] ch;
        logic [CpW-1:0] floor_cp;
        step_n = 0;
        if (bytes_wanted == 2'd0)
            fresh_byte(b, eos);
        else if (b[7:6] == 2'b10)
        begin
            ch = {accum[CpW-7:0], b[5:0]};
            if (bytes_wanted == 2'd1)
            begin
                if (lead_held[7:5] == 3'b110)
                    floor_cp = MinTwo;
                else if (lead_held[7:4] == 4'b1110)
                    floor_cp = MinThree;
                else
                    floor_cp = MinFour;
                if (ch < floor_cp || ch[CpW-1:11] == SurrHigh)
                begin
                    flush_held();
                    add_escape(b);
                end
                else
                begin
                    add_result(ch, 1'b0);
                    close_sequence();
                end
            end
            else if (eos)
            begin
                flush_held();
                add_escape(b);
            end
            else
            begin
                follow_buf[follow_count[0]] = b;
                follow_count = follow_count + 2'd1;
                bytes_wanted = bytes_wanted - 2'd1;
                accum        = ch;
            end
        end
        else
        begin
            flush_held();
            fresh_byte(b, eos);
        end
        for (int k = 0; k < step_n; k++)
        begin
            if (k == step_n - 1)
                step_res[k].last = 1'b1;
            expected_cps.push_back(step_res[k]);
        end
    endtask

    task automatic send(input logic [ByteW-1:0] b, input logic eos);
        text_byte_t t;
        t.b   = b;
        t.eos = eos;
        pending_bytes.push_back(t);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 22))
            begin
                next_byte = pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_byte.b;
                s_axis_tlast  <= next_byte.eos;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 22);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_cps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual %h %b %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    want = expected_cps.pop_front();
                    if (m_axis_tdata !== {{(OutDataW-CpW){1'b0}}, want.cp})
                    begin
                        errors++;
                        $display("%0t: code_point mismatch, expected %h, actual %h",
                                 $time, want.cp, m_axis_tdata);
                    end
                    if (m_axis_tuser[0] !== want.esc)
                    begin
                        errors++;
                        $display("%0t: is_escape mismatch, expected %b, actual %b",
                                 $time, want.esc, m_axis_tuser[0]);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_of_run mismatch, expected %b, actual %b",
                                 $time, want.last, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                n_accepted++;
            end
        end
    end

    initial
    begin
        logic [ByteW-1:0] str[$];
        logic [ByteW-1:0] c;
        int n_sent;
        int len;
        int kind;
        int nb;
        int cut;

        // ascii extremes, bad leads, lead at end of string
        send(8'h00, 1'b0);
        send(8'h7F, 1'b0);
        send(8'h80, 1'b0);
        send(8'hFF, 1'b0);
        send(8'hC3, 1'b1);
        // valid two, three byte forms and the largest value
        send(8'hC3, 1'b0);
        send(8'hA9, 1'b0);
        send(8'hE2, 1'b0);
        send(8'h82, 1'b0);
        send(8'hAC, 1'b0);
        send(8'hF7, 1'b0);
        send(8'hBF, 1'b0);
        send(8'hBF, 1'b0);
        send(8'hBF, 1'b0);
        // overlong, surrogate
        send(8'hC0, 1'b0);
        send(8'h80, 1'b0);
        send(8'hED, 1'b0);
        send(8'hA0, 1'b0);
        send(8'h80, 1'b0);
        // broken by a non-continuation with two bytes buffered
        send(8'hF0, 1'b0);
        send(8'h9F, 1'b0);
        send(8'h98, 1'b0);
        send(8'h41, 1'b0);
        // string ends inside a sequence
        send(8'hE2, 1'b0);
        send(8'h82, 1'b1);
        send(8'hF8, 1'b1);
        n_sent = 26;

        while (n_sent < 222)
        begin
            str.delete();
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 8)
                    str.push_back(8'($urandom));
                else if (kind < 30)
                    str.push_back({1'b0, 7'($urandom)});
                else
                begin
                    nb = (kind < 55) ? 2 : (kind < 80) ? 3 : 4;
                    case (nb)
                        2: c = {3'b110, 5'($urandom)};
                        3: c = {4'b1110, 4'($urandom)};
                        default: c = {5'b11110, 3'($urandom)};
                    endcase
                    str.push_back(c);
                    cut = nb;
                    if ($urandom_range(0, 9) == 0)
                        cut = $urandom_range(1, nb - 1);
                    for (int j = 1; j < cut; j++)
                    begin
                        c = {2'b10, 6'($urandom)};
                        if ($urandom_range(0, 19) == 0)
                            c = 8'($urandom);
                        str.push_back(c);
                    end
                end
            end
            for (int i = 0; i < str.size(); i++)
                send(str[i], i == str.size() - 1);
            n_sent += str.size();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_cps.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0 && expected_cps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ utf8_decoder_with_error_escape.f @@
src/u8d_pkg.sv
src/u8d_decode.sv
src/utf8_decoder_with_error_escape.sv
dv/utf8_decoder_with_error_escape_tb.sv
